>>> sv/rsce_pkg.sv
// ----------------------------------------------------------------------------
// rsce_pkg
// Types and constants shared by the radiotap signal/channel extractor.
// ----------------------------------------------------------------------------
package rsce_pkg;

  localparam int unsigned MAX_FRAME_BYTES_DEF = 65535;

  localparam logic [15:0] DEFAULT_FREQ_RESET = 16'd2412;
  localparam logic [15:0] FIELDS_BASE_RESET  = 16'd8;

  // present bitmap bit positions
  localparam int unsigned PRESENT_TSFT    = 0;
  localparam int unsigned PRESENT_FLAGS   = 1;
  localparam int unsigned PRESENT_RATE    = 2;
  localparam int unsigned PRESENT_CHANNEL = 3;
  localparam int unsigned PRESENT_DBM     = 5;
  localparam int unsigned PRESENT_EXT     = 31;

  // header byte positions
  localparam int unsigned POS_LEN_LO  = 2;
  localparam int unsigned POS_LEN_HI  = 3;
  localparam int unsigned POS_PRES_LO = 4;
  localparam int unsigned POS_PRES_HI = 7;
  localparam int unsigned MIN_FRAME   = 8;

  // skip sizes
  localparam logic [17:0] TSFT_BYTES = 18'd8;
  localparam logic [17:0] CHAN_BYTES = 18'd4;
  localparam logic [17:0] EXT_BYTES  = 18'd4;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_beat_t;

  typedef struct packed {
    logic signed [7:0] signal_dbm;
    logic              signal_found;
    logic [15:0]       channel_mhz;
    logic              channel_found;
    logic [15:0]       header_length;
    logic [15:0]       payload_length;
    logic              header_overrun;
  } out_beat_t;

endpackage

>>> sv/rsce_stream_if.sv
// ----------------------------------------------------------------------------
// rsce_stream_if
// Valid/ready stream channel carrying one beat of a given payload type.
// ----------------------------------------------------------------------------
interface rsce_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

>>> sv/radiotap_signal_channel_extract_core.sv
// ----------------------------------------------------------------------------
// radiotap_signal_channel_extract_core
// Streams frame bytes, walks the radiotap present words and picks out the
// channel frequency and dBm antenna signal; one result beat per 8+ byte frame.
// ----------------------------------------------------------------------------
// Path: a frame's last byte sits in the input register, then its result
// beat in the result register. Throughput: one byte beat per cycle while
// the result side is not stalled; the per-byte offset compare sets the cycle.
// Reset: rst (synchronous) empties both registers, clears frame state and
// sets the default frequency to 2412 MHz.
// ----------------------------------------------------------------------------
module radiotap_signal_channel_extract_core import rsce_pkg::*; #(
  parameter int unsigned MAX_FRAME_BYTES = MAX_FRAME_BYTES_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_wr_en,
  input  logic [15:0]          cfg_wr_data,
  rsce_stream_if.sink          frame,
  rsce_stream_if.source        result
);

  localparam int unsigned POS_W = $clog2(MAX_FRAME_BYTES + 1);

  logic [15:0]      default_freq;

  // input register
  logic             in_valid;
  in_beat_t         in_beat;

  // frame state
  logic [POS_W-1:0] byte_position, byte_position_next;
  logic [15:0]      hdr_len, hdr_len_next;
  logic [31:0]      first_present, first_present_next;
  logic [15:0]      fields_base, fields_base_next;
  logic             ext_walking, ext_walking_next;
  logic [15:0]      freq_capture, freq_capture_next;
  logic [7:0]       signal_capture, signal_capture_next;
  logic             chan_found, chan_found_next;
  logic             sig_found, sig_found_next;

  // result register
  logic             out_valid;
  out_beat_t        out_beat, out_beat_next;

  logic             step;
  logic             emit;
  logic             take;
  logic [7:0]       b;
  logic [17:0]      pos18, hlen18, base18, o_pre, ch_off, sig_off;
  logic [1:0]       k;
  logic [POS_W:0]   caplen;

  assign step         = in_valid && (!out_valid || result.ready);
  assign frame.ready  = !in_valid || step;
  assign result.valid = out_valid;
  assign result.payload = out_beat;

  assign b      = in_beat.data_byte;
  assign take   = byte_position < POS_W'(MAX_FRAME_BYTES);
  assign pos18  = 18'(byte_position);
  assign hlen18 = 18'(hdr_len);
  assign base18 = 18'(fields_base);
  assign k      = 2'(byte_position - POS_W'(fields_base));

  always_comb begin
    o_pre = base18;
    if (first_present[PRESENT_TSFT]) o_pre = o_pre + TSFT_BYTES;
    o_pre = o_pre + 18'(first_present[PRESENT_FLAGS]) + 18'(first_present[PRESENT_RATE]);
    if (first_present[PRESENT_CHANNEL]) begin
      ch_off  = o_pre + 18'(o_pre[0]);
      sig_off = ch_off + CHAN_BYTES;
    end else begin
      ch_off  = o_pre;
      sig_off = o_pre;
    end
  end

  always_comb begin
    hdr_len_next        = hdr_len;
    first_present_next  = first_present;
    fields_base_next    = fields_base;
    ext_walking_next    = ext_walking;
    freq_capture_next   = freq_capture;
    signal_capture_next = signal_capture;
    chan_found_next     = chan_found;
    sig_found_next      = sig_found;
    byte_position_next  = byte_position;

    if (take) begin
      byte_position_next = byte_position + POS_W'(1);
      priority if (byte_position == POS_W'(POS_LEN_LO)) begin
        hdr_len_next[7:0] = b;
      end else if (byte_position == POS_W'(POS_LEN_HI)) begin
        hdr_len_next[15:8] = b;
      end else if (byte_position >= POS_W'(POS_PRES_LO)
                   && byte_position <= POS_W'(POS_PRES_HI)) begin
        first_present_next[8*(byte_position[1:0]) +: 8] = b;
        if (byte_position == POS_W'(POS_PRES_HI)) begin
          fields_base_next = FIELDS_BASE_RESET;
          ext_walking_next = b[7] && (18'(FIELDS_BASE_RESET) + EXT_BYTES <= hlen18);
        end
      end else if (byte_position < POS_W'(MIN_FRAME)) begin
        // bytes 0 and 1: version and pad
      end else if (ext_walking) begin
        if (k == 2'd3) begin
          fields_base_next = fields_base + 16'd4;
          ext_walking_next = b[7] && (base18 + EXT_BYTES + EXT_BYTES <= hlen18);
        end
      end else begin
        if (first_present[PRESENT_CHANNEL] && (ch_off + 18'd2 <= hlen18)) begin
          if (pos18 == ch_off) freq_capture_next[7:0] = b;
          if (pos18 == ch_off + 18'd1) begin
            freq_capture_next[15:8] = b;
            chan_found_next         = 1'b1;
          end
        end
        if (first_present[PRESENT_DBM] && (sig_off + 18'd1 <= hlen18)
            && pos18 == sig_off) begin
          signal_capture_next = b;
          sig_found_next      = 1'b1;
        end
      end
    end
  end

  assign caplen = (POS_W + 1)'(byte_position_next);
  assign emit   = in_beat.last_byte && (caplen >= (POS_W + 1)'(MIN_FRAME));

  always_comb begin
    out_beat_next.signal_dbm     = sig_found_next ? signed'(signal_capture_next) : 8'sd0;
    out_beat_next.signal_found   = sig_found_next;
    out_beat_next.channel_mhz    = chan_found_next ? freq_capture_next : default_freq;
    out_beat_next.channel_found  = chan_found_next;
    out_beat_next.header_length  = hdr_len_next;
    if (17'(caplen) >= 17'(hdr_len_next)) begin
      out_beat_next.payload_length = 16'(17'(caplen) - 17'(hdr_len_next));
      out_beat_next.header_overrun = 1'b0;
    end else begin
      out_beat_next.payload_length = 16'd0;
      out_beat_next.header_overrun = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      default_freq <= DEFAULT_FREQ_RESET;
    end else if (cfg_wr_en) begin
      default_freq <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (frame.valid && frame.ready) begin
      in_beat <= frame.payload;
    end
    if (step && emit) begin
      out_beat <= out_beat_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (frame.valid && frame.ready) begin
        in_valid <= 1'b1;
      end else if (step) begin
        in_valid <= 1'b0;
      end
      if (step && emit) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (step && in_beat.last_byte)) begin
      byte_position  <= '0;
      hdr_len        <= '0;
      first_present  <= '0;
      fields_base    <= FIELDS_BASE_RESET;
      ext_walking    <= 1'b0;
      freq_capture   <= '0;
      signal_capture <= '0;
      chan_found     <= 1'b0;
      sig_found      <= 1'b0;
    end else if (step) begin
      byte_position  <= byte_position_next;
      hdr_len        <= hdr_len_next;
      first_present  <= first_present_next;
      fields_base    <= fields_base_next;
      ext_walking    <= ext_walking_next;
      freq_capture   <= freq_capture_next;
      signal_capture <= signal_capture_next;
      chan_found     <= chan_found_next;
      sig_found      <= sig_found_next;
    end
  end

endmodule

>>> sv/rsce_checker.sv
// ----------------------------------------------------------------------------
// rsce_checker
// Port-level checks on the extractor, bound to its core module.
// ----------------------------------------------------------------------------
module rsce_checker (
  input logic              clk,
  input logic              rst,
  input logic              out_valid,
  input logic              out_ready,
  input logic signed [7:0] signal_dbm,
  input logic              signal_found,
  input logic [15:0]       payload_length,
  input logic              header_overrun
);

  // a stalled result beat stays offered
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped while stalled");

  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result beat after reset");

  a_overrun: assert property (@(posedge clk) disable iff (rst)
    out_valid && header_overrun |-> payload_length == 16'd0)
    else $error("payload length not saturated on overrun");

  a_no_sig: assert property (@(posedge clk) disable iff (rst)
    out_valid && !signal_found |-> signal_dbm == 8'sd0)
    else $error("signal value without signal found");

endmodule

bind radiotap_signal_channel_extract_core rsce_checker u_rsce_checker (
  .clk            (clk),
  .rst            (rst),
  .out_valid      (result.valid),
  .out_ready      (result.ready),
  .signal_dbm     (result.payload.signal_dbm),
  .signal_found   (result.payload.signal_found),
  .payload_length (result.payload.payload_length),
  .header_overrun (result.payload.header_overrun)
);

>>> tb/sv/rsce_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rsce_tb_checker
// Watches the byte and result channels of the radiotap extractor, predicts
// each frame's result from the bytes seen and compares it field by field.
// ----------------------------------------------------------------------------
module rsce_tb_checker import rsce_pkg::*; #(
  parameter int unsigned MAX_FRAME_BYTES = MAX_FRAME_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,
  input  logic        frame_valid,
  input  logic        frame_ready,
  input  in_beat_t    frame_beat,
  input  logic        result_valid,
  input  logic        result_ready,
  input  out_beat_t   result_beat,
  output int          mismatches,
  output int          waiting,
  output int          results_seen
);

  logic [15:0] dflt_freq;
  logic [15:0] n_bytes;
  logic [15:0] hdr_len;
  logic [15:0] base;
  logic [15:0] freq_cap;
  logic [31:0] present;
  logic [31:0] ext_w;
  logic [7:0]  sig_cap;
  logic        walking;
  logic        chan_ok;
  logic        sig_ok;

  out_beat_t   due_results[$];

  function void clear_frame();
    n_bytes  = '0;
    hdr_len  = '0;
    present  = '0;
    ext_w    = '0;
    base     = FIELDS_BASE_RESET;
    walking  = 1'b0;
    freq_cap = '0;
    sig_cap  = '0;
    chan_ok  = 1'b0;
    sig_ok   = 1'b0;
  endfunction

  function void absorb_byte(input int unsigned at, input logic [7:0] b);
    int unsigned hl;
    int unsigned o;
    int unsigned ch;
    int unsigned k;
    hl = 32'(hdr_len);
    if (at == POS_LEN_LO) begin
      hdr_len[7:0] = b;
    end else if (at == POS_LEN_HI) begin
      hdr_len[15:8] = b;
    end else if (at >= POS_PRES_LO && at <= POS_PRES_HI) begin
      present[8*(at-POS_PRES_LO) +: 8] = b;
      if (at == POS_PRES_HI) begin
        ext_w   = present;
        base    = FIELDS_BASE_RESET;
        walking = present[PRESENT_EXT] && (32'(base) + 32'd4 <= hl);
      end
    end else if (at >= MIN_FRAME) begin
      if (walking) begin
        k = (at - 32'(base)) & 32'd3;
        ext_w[8*k +: 8] = b;
        if (k == 3) begin
          base    = base + 16'd4;
          walking = ext_w[PRESENT_EXT] && (32'(base) + 32'd4 <= hl);
        end
      end else begin
        o  = 32'(base);
        ch = o;
        if (present[PRESENT_TSFT])  o += 8;
        if (present[PRESENT_FLAGS]) o += 1;
        if (present[PRESENT_RATE])  o += 1;
        if (present[PRESENT_CHANNEL]) begin
          if (o[0]) o += 1;
          ch = o;
          o += 4;
          if (ch + 2 <= hl) begin
            if (at == ch) freq_cap[7:0] = b;
            if (at == ch + 1) begin
              freq_cap[15:8] = b;
              chan_ok = 1'b1;
            end
          end
        end
        if (present[PRESENT_DBM] && o + 1 <= hl && at == o) begin
          sig_cap = b;
          sig_ok  = 1'b1;
        end
      end
    end
  endfunction

  function void take_beat(input in_beat_t bt);
    out_beat_t r;
    if (n_bytes < MAX_FRAME_BYTES) begin
      absorb_byte(32'(n_bytes), bt.data_byte);
      n_bytes = n_bytes + 16'd1;
    end
    if (bt.last_byte) begin
      if (n_bytes >= MIN_FRAME) begin
        r.signal_dbm     = sig_ok ? sig_cap : '0;
        r.signal_found   = sig_ok;
        r.channel_mhz    = chan_ok ? freq_cap : dflt_freq;
        r.channel_found  = chan_ok;
        r.header_length  = hdr_len;
        r.payload_length = (n_bytes >= hdr_len) ? n_bytes - hdr_len : '0;
        r.header_overrun = hdr_len > n_bytes;
        due_results.push_back(r);
        waiting++;
      end
      clear_frame();
    end
  endfunction

  function void check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  function void check_result(input out_beat_t got);
    out_beat_t want;
    results_seen++;
    if (due_results.size() == 0) begin
      $error("result beat with no frame outstanding");
      mismatches++;
    end else begin
      want = due_results.pop_front();
      waiting--;
      check_field("signal_dbm", int'($signed(want.signal_dbm)),
                  int'($signed(got.signal_dbm)));
      check_field("signal_found", int'(want.signal_found), int'(got.signal_found));
      check_field("channel_mhz", int'(want.channel_mhz), int'(got.channel_mhz));
      check_field("channel_found", int'(want.channel_found), int'(got.channel_found));
      check_field("header_length", int'(want.header_length), int'(got.header_length));
      check_field("payload_length", int'(want.payload_length),
                  int'(got.payload_length));
      check_field("header_overrun", int'(want.header_overrun),
                  int'(got.header_overrun));
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      dflt_freq    = DEFAULT_FREQ_RESET;
      mismatches   = 0;
      waiting      = 0;
      results_seen = 0;
      due_results.delete();
      clear_frame();
    end else begin
      if (result_valid && result_ready) check_result(result_beat);
      if (cfg_wr_en) dflt_freq = cfg_wr_data;
      if (frame_valid && frame_ready) take_beat(frame_beat);
    end
  end

endmodule

>>> tb/sv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Feeds radiotap frames byte by byte into the extractor: directed frames for
// layouts and corner cases, then random frames under varying idle and stall
// patterns and default frequencies, with one long result-side hold-off.
// ----------------------------------------------------------------------------
module tb_top;
  import rsce_pkg::*;

  localparam int HOLD_CYCLES    = 400;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 10;
  localparam int PHASE_BYTES    = 380;

  localparam logic [31:0] M_TSFT  = 32'h1 << PRESENT_TSFT;
  localparam logic [31:0] M_FLAGS = 32'h1 << PRESENT_FLAGS;
  localparam logic [31:0] M_RATE  = 32'h1 << PRESENT_RATE;
  localparam logic [31:0] M_CHAN  = 32'h1 << PRESENT_CHANNEL;
  localparam logic [31:0] M_DBM   = 32'h1 << PRESENT_DBM;
  localparam logic [31:0] M_EXT   = 32'h1 << PRESENT_EXT;
  localparam logic [31:0] M_ALL   = M_TSFT | M_FLAGS | M_RATE | M_CHAN | M_DBM;

  logic        clk = 1'b0;
  logic        rst;
  logic        cfg_wr_en;
  logic [15:0] cfg_wr_data;

  int tx_idle_pct  = 0;
  int rx_stall_pct = 0;
  bit hold_go      = 1'b0;
  bit hold_done    = 1'b0;
  int frames_sent  = 0;
  int bytes_sent   = 0;
  int cfg_writes   = 0;
  int held_back    = 0;
  int idle_cycles  = 0;

  int mismatches;
  int waiting;
  int results_seen;

  rsce_stream_if #(.payload_t(in_beat_t))  frame_if ();
  rsce_stream_if #(.payload_t(out_beat_t)) result_if ();

  radiotap_signal_channel_extract_core uut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .frame       (frame_if),
    .result      (result_if)
  );

  rsce_tb_checker chk (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .frame_valid  (frame_if.valid),
    .frame_ready  (frame_if.ready),
    .frame_beat   (frame_if.payload),
    .result_valid (result_if.valid),
    .result_ready (result_if.ready),
    .result_beat  (result_if.payload),
    .mismatches   (mismatches),
    .waiting      (waiting),
    .results_seen (results_seen)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // result side: random stalls, one long hold-off on request
  initial begin
    result_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_go && !hold_done) begin
        result_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end
      result_if.ready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  initial begin
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (frame_if.valid && !frame_if.ready) held_back++;
      if (rst || (frame_if.valid && frame_if.ready) || (result_if.valid && result_if.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("Timeout: no beat for %0d cycles", WATCHDOG_LIMIT);
    $display("Simulation FAILED");
    $finish;
  end

  task automatic send_byte(input logic [7:0] v, input logic l);
    while ($urandom_range(99) < tx_idle_pct) begin
      frame_if.valid <= 1'b0;
      @(posedge clk);
    end
    frame_if.valid   <= 1'b1;
    frame_if.payload <= '{data_byte: v, last_byte: l};
    do @(posedge clk); while (!frame_if.ready);
    bytes_sent++;
  endtask

  // header: length, present word, n_ext extension words, then fill bytes
  task automatic send_frame(input logic [15:0] hlen, input logic [31:0] pres,
                            input int n_ext, input int cap, input int fill);
    logic [31:0] ext[4];
    logic [31:0] p;
    logic [7:0]  v;
    p = pres;
    if (n_ext > 0) p[PRESENT_EXT] = 1'b1;
    for (int j = 0; j < 4; j++) begin
      ext[j] = $urandom();
      ext[j][PRESENT_EXT] = (j < n_ext - 1);
    end
    for (int i = 0; i < cap; i++) begin
      if (i < 2)                v = 8'($urandom_range(255));
      else if (i == 2)          v = hlen[7:0];
      else if (i == 3)          v = hlen[15:8];
      else if (i < 8)           v = p[8*(i-4) +: 8];
      else if (i < 8 + 4*n_ext) v = ext[(i-8)/4][8*((i-8)%4) +: 8];
      else if (fill < 0)        v = 8'($urandom_range(255));
      else                      v = 8'(fill);
      send_byte(v, i == cap - 1);
    end
    frames_sent++;
  endtask

  task automatic random_frame();
    logic [31:0] pres;
    int n_ext;
    int r;
    int hl;
    int cap;
    int fill;
    pres  = $urandom();
    n_ext = 0;
    if ($urandom_range(99) < 80) begin
      pres[PRESENT_EXT] = 1'b0;
      if ($urandom_range(3) == 0) n_ext = $urandom_range(3, 1);
      if ($urandom_range(1)) pres = pres | M_CHAN | M_DBM;
    end
    r = $urandom_range(99);
    if (r < 80)      hl = 8 + 4*n_ext + $urandom_range(24);
    else if (r < 92) hl = $urandom_range(12);
    else             hl = $urandom_range(65535);
    r = $urandom_range(99);
    if (r < 8)       cap = $urandom_range(7, 1);
    else if (hl > 64) cap = $urandom_range(64, 8);
    else if (r < 22) cap = $urandom_range(hl < 8 ? 8 : hl, 8);
    else             cap = hl + $urandom_range(12);
    if (cap < 1) cap = 1;
    fill = ($urandom_range(15) == 0) ? int'($urandom_range(255)) : -1;
    send_frame(16'(hl), pres, n_ext, cap, fill);
  endtask

  task automatic random_phase(input int budget);
    int start;
    start = bytes_sent;
    while (bytes_sent - start < budget) random_frame();
  endtask

  // wait until every due result is out, then let the pipeline empty
  task automatic settle();
    frame_if.valid <= 1'b0;
    do @(posedge clk); while (waiting != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_default(input logic [15:0] v);
    settle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    cfg_writes++;
  endtask

  initial begin
    rst              <= 1'b1;
    cfg_wr_en        <= 1'b0;
    cfg_wr_data      <= '0;
    frame_if.valid   <= 1'b0;
    frame_if.payload <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed, reset default frequency, no idling
    send_frame(16'd8, '0, 0, 8, -1);
    send_frame(16'd23, M_ALL, 0, 30, -1);
    send_frame(16'd15, M_FLAGS | M_CHAN | M_DBM, 0, 15, 8'hFF);  // padded to even
    send_frame(16'd13, M_CHAN | M_DBM, 0, 13, 8'h80);
    send_frame(16'd9, M_DBM, 0, 9, 8'h7F);
    send_frame(16'd12, M_CHAN, 0, 16, 8'h00);
    send_frame(16'd35, M_ALL, 3, 40, -1);
    send_frame(16'd10, M_ALL | M_EXT, 0, 14, -1);   // no room for extension word
    send_frame(16'd20, M_CHAN | M_EXT, 0, 24, -1);  // walk runs into field bytes
    send_frame(16'd40, M_CHAN | M_DBM, 0, 14, -1);  // header beyond capture
    send_frame(16'd40, M_CHAN | M_DBM, 0, 9, -1);   // frequency cut off
    send_frame(16'd4, M_ALL, 0, 20, -1);
    send_frame(16'd0, M_CHAN, 0, 8, -1);
    send_frame(16'hFFFF, M_CHAN | M_DBM, 0, 20, -1);
    send_frame(16'd9, M_CHAN | M_DBM, 0, 12, -1);   // channel past header end
    send_frame(16'd30, 32'h7FFF_FFFF, 0, 30, -1);
    send_frame(16'd20, M_CHAN, 0, 1, -1);
    send_frame(16'd20, M_CHAN, 0, 7, -1);
    send_frame(16'd8, '0, 0, 8, 8'hFF);

    write_default(16'd0);
    random_phase(PHASE_BYTES);

    write_default(16'hFFFF);
    tx_idle_pct = 48;
    random_phase(PHASE_BYTES);

    write_default(16'($urandom_range(65535)));
    tx_idle_pct  = 0;
    rx_stall_pct = 48;
    random_phase(PHASE_BYTES);

    write_default(16'd2437);
    tx_idle_pct  = 25;
    rx_stall_pct = 25;
    hold_go      = 1'b1;
    repeat (20) send_frame(16'd13, M_CHAN | M_DBM, 0, 13, -1);
    random_phase(PHASE_BYTES - 260);

    settle();
    $display("Sent %0d frames (%0d bytes) under %0d default frequencies; %0d results checked.",
             frames_sent, bytes_sent, cfg_writes + 1, results_seen);
    $display("Byte input held back for %0d cycles; %0d mismatches.", held_back, mismatches);
    if (mismatches == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
